// ----- rtl/e2q_pkg.sv -----
// Package for the Euler-to-quaternion core: CORDIC constants and arctangent table.
`timescale 1ns / 1ps
package e2q_pkg;
    localparam int CW = 34;                 // CORDIC x/y/z width (Q30 plus sign/growth)
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    function automatic logic signed [33:0] atan_entry(input int idx);
        logic signed [33:0] t;
        begin
            case (idx)
                0: t = 34'sd536870912;
                1: t = 34'sd316933406;
                2: t = 34'sd167458907;
                3: t = 34'sd85004756;
                4: t = 34'sd42667331;
                5: t = 34'sd21354465;
                6: t = 34'sd10679838;
                7: t = 34'sd5340245;
                8: t = 34'sd2670163;
                9: t = 34'sd1335087;
                10: t = 34'sd667544;
                11: t = 34'sd333772;
                12: t = 34'sd166886;
                13: t = 34'sd83443;
                14: t = 34'sd41722;
                15: t = 34'sd20861;
                16: t = 34'sd10430;
                17: t = 34'sd5215;
                18: t = 34'sd2608;
                19: t = 34'sd1304;
                20: t = 34'sd652;
                21: t = 34'sd326;
                22: t = 34'sd163;
                23: t = 34'sd81;
                24: t = 34'sd41;
                25: t = 34'sd20;
                26: t = 34'sd10;
                27: t = 34'sd5;
                28: t = 34'sd3;
                29: t = 34'sd1;
                30: t = 34'sd1;
                default: t = 34'sd0;
            endcase
            atan_entry = t;
        end
    endfunction

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_t;

    typedef struct packed {
        cordic_t r;
        cordic_t p;
        cordic_t w;
    } triple_t;
endpackage

// ----- rtl/e2q_cordic_cell.sv -----
// One CORDIC rotation cell: rotates three angle channels by one step and registers them.
`timescale 1ns / 1ps
module e2q_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  e2q_pkg::triple_t    in_data,
    output logic                out_valid,
    output e2q_pkg::triple_t    out_data
);
    localparam int K = STEP % 32;
    localparam logic signed [33:0] T = e2q_pkg::atan_entry(K);

    e2q_pkg::triple_t data_reg, data_next;
    logic             valid_reg;

    function automatic e2q_pkg::cordic_t rotate(input e2q_pkg::cordic_t c);
        e2q_pkg::cordic_t o;
        logic signed [33:0] dx, dy;
        begin
            dx = c.y >>> K;
            dy = c.x >>> K;
            if (!c.z[33])
            begin
                o.x = c.x - dx;
                o.y = c.y + dy;
                o.z = c.z - T;
            end
            else
            begin
                o.x = c.x + dx;
                o.y = c.y - dy;
                o.z = c.z + T;
            end
            rotate = o;
        end
    endfunction

    // Rotate each channel by this step's angle
    always_comb
    begin
        data_next.r = rotate(in_data.r);
        data_next.p = rotate(in_data.p);
        data_next.w = rotate(in_data.w);
    end

    // Advance the word when the pipe moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ----- rtl/e2q_combine.sv -----
// Quaternion combine pipeline: products of sines and cosines, sums, rounding and saturation.
`timescale 1ns / 1ps
module e2q_combine #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  e2q_pkg::triple_t                  in_data,
    output logic                              out_valid,
    output logic signed [COMPONENT_BITS-1:0]  qx,
    output logic signed [COMPONENT_BITS-1:0]  qy,
    output logic signed [COMPONENT_BITS-1:0]  qz,
    output logic signed [COMPONENT_BITS-1:0]  qw
);
    localparam int FB = COMPONENT_BITS - 1;
    localparam int SH = 60 - FB;

    // stage 1: pair products, floor to Q30
    logic signed [33:0] cy_reg, sy_reg;
    logic signed [33:0] srcp_reg, crsp_reg, crcp_reg, srsp_reg;
    // stage 2: triple products
    logic signed [67:0] t_reg [8];
    // stage 3: sums
    logic signed [68:0] s_reg [4];
    logic [2:0] v_reg;

    logic signed [67:0] m0, m1, m2, m3;
    assign m0 = in_data.r.y * in_data.p.x;
    assign m1 = in_data.r.x * in_data.p.y;
    assign m2 = in_data.r.x * in_data.p.x;
    assign m3 = in_data.r.y * in_data.p.y;

    // Track valid through the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srcp_reg <= m0[63:30];
            crsp_reg <= m1[63:30];
            crcp_reg <= m2[63:30];
            srsp_reg <= m3[63:30];
            cy_reg   <= in_data.w.x;
            sy_reg   <= in_data.w.y;
            t_reg[0] <= srcp_reg * cy_reg;
            t_reg[1] <= crsp_reg * sy_reg;
            t_reg[2] <= crsp_reg * cy_reg;
            t_reg[3] <= srcp_reg * sy_reg;
            t_reg[4] <= crcp_reg * sy_reg;
            t_reg[5] <= srsp_reg * cy_reg;
            t_reg[6] <= crcp_reg * cy_reg;
            t_reg[7] <= srsp_reg * sy_reg;
            s_reg[0] <= 69'(t_reg[0]) - 69'(t_reg[1]);
            s_reg[1] <= 69'(t_reg[2]) + 69'(t_reg[3]);
            s_reg[2] <= 69'(t_reg[4]) - 69'(t_reg[5]);
            s_reg[3] <= 69'(t_reg[6]) + 69'(t_reg[7]);
        end
    end

    function automatic logic signed [COMPONENT_BITS-1:0] round_sat(input logic signed [68:0] v);
        logic signed [68:0] r;
        logic signed [68:0] hi, lo;
        begin
            hi = (69'sd1 <<< FB) - 69'sd1;
            lo = -(69'sd1 <<< FB);
            r = (v + (69'sd1 <<< (SH - 1))) >>> SH;
            if (r > hi)
                r = hi;
            if (r < lo)
                r = lo;
            round_sat = r[COMPONENT_BITS-1:0];
        end
    endfunction

    // Round and saturate in the output stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx <= round_sat(s_reg[0]);
            qy <= round_sat(s_reg[1]);
            qz <= round_sat(s_reg[2]);
            qw <= round_sat(s_reg[3]);
        end
    end

    logic ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= v_reg[2];
    end
    assign out_valid = ov_reg;
endmodule

// ----- rtl/euler_angles_to_quaternion_core.sv -----
// Path: CORDIC cell registers, then pair-product, triple-product, sum and output stages.
// Throughput: one word per cycle while not stalled; the chain of CORDIC cells and combine
// stages all advance together whenever the output register is empty or being taken.
// Reset: rst_n clears all valid flags asynchronously; no data is lost after reset.
// Top level of the Euler-angle to quaternion core.
`timescale 1ns / 1ps
module euler_angles_to_quaternion_core #(
    parameter int ANGLE_BITS     = 16,
    parameter int COMPONENT_BITS = 16,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // roll_angle, pitch_angle, yaw_angle from bit 0 up
    input  logic [3*ANGLE_BITS-1:0]       s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // quat_x, quat_y, quat_z, quat_w from bit 0 up
    output logic [4*COMPONENT_BITS-1:0]   m_tdata
);
    logic en;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    function automatic e2q_pkg::cordic_t seed(input logic signed [ANGLE_BITS-1:0] a);
        e2q_pkg::cordic_t c;
        logic signed [63:0] wide;
        begin
            wide = 64'(a) <<< 31;
            c.x = e2q_pkg::CORDIC_GAIN;
            c.y = '0;
            c.z = 34'(wide >>> ANGLE_BITS);
            seed = c;
        end
    endfunction

    e2q_pkg::triple_t chain_data [CORDIC_STEPS+1];
    logic             chain_valid [CORDIC_STEPS+1];

    // Seed the chain with the halved angles
    assign chain_valid[0] = s_tvalid;
    assign chain_data[0].r = seed(s_tdata[ANGLE_BITS-1:0]);
    assign chain_data[0].p = seed(s_tdata[2*ANGLE_BITS-1:ANGLE_BITS]);
    assign chain_data[0].w = seed(s_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]);

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        e2q_cordic_cell #(.STEP(i)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(chain_valid[i]), .in_data(chain_data[i]),
            .out_valid(chain_valid[i+1]), .out_data(chain_data[i+1])
        );
    end

    logic signed [COMPONENT_BITS-1:0] qx, qy, qz, qw;
    e2q_combine #(.COMPONENT_BITS(COMPONENT_BITS)) u_comb (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(chain_valid[CORDIC_STEPS]), .in_data(chain_data[CORDIC_STEPS]),
        .out_valid(m_tvalid), .qx(qx), .qy(qy), .qz(qz), .qw(qw)
    );
    assign m_tdata = {qw, qz, qy, qx};

`ifndef SYNTH
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall lost word");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready) else $error("ready low with empty output");
    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> chain_valid[1]) else $error("accepted word not in chain");
`endif
endmodule
